// ----- hw/rtl/bsfr_pkg.sv -----
// Shared types and constants for the bit stream field reader.
package bsfr_pkg;

	localparam int BUFFER_BYTES_DEF   = 4096;
	localparam int MAX_FIELD_BITS_DEF = 64;
	localparam int BYTE_BITS          = 8;
	localparam int FIELD_BITS         = 64;
	localparam int POS_BITS           = 16;
	localparam int REQ_BITS           = 3;
	localparam int CNT_BITS           = 7;
	// A 64-bit field at a nonzero bit offset touches up to nine bytes.
	localparam int WIN_BYTES          = 9;
	localparam int WIN_BITS           = WIN_BYTES * BYTE_BITS;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_LOAD   = 3'd0,
		REQ_RD_MSB = 3'd1,
		REQ_RD_LSB = 3'd2,
		REQ_SKIP   = 3'd3,
		REQ_BACK   = 3'd4,
		REQ_CHECK  = 3'd5,
		REQ_CLEAR  = 3'd6
	} req_e_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FETCH,
		ST_EXTRACT,
		ST_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic latch;
		logic exec;
		logic fetch;
		logic extract;
		logic out_load;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic read_go;
		logic fetch_done;
	} sts_t;

endpackage

// ----- hw/rtl/bit_stream_field_reader.sv -----
// Bit stream field reader: non-reads and unfit reads step from execute to done.
// Reads fetch n bytes, n = ceil((bit offset + bit count) / 8), up to 9, one per
// cycle from the single-port byte store, then extract the field, then done.
// One item is in work at a time; a finished result waits in the output register.
// Reset clears loaded count and position; byte store contents are not cleared.
module bit_stream_field_reader import bsfr_pkg::*; #(
	parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
	parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // byte_value[7:0], bit_count[14:8], zero[15]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // field_value[63:0], bit_position[79:64]
	output logic [0:0]  m_tuser   // ok[0]
);

	cmd_t cmd;
	sts_t st;

	bsfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bsfr_dp #(
		.BUFFER_BYTES   (BUFFER_BYTES),
		.MAX_FIELD_BITS (MAX_FIELD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_req    (s_tuser),
		.in_byte   (s_tdata[7:0]),
		.in_cnt    (s_tdata[14:8]),
		.out_value (m_tdata[63:0]),
		.out_ok    (m_tuser[0]),
		.out_pos   (m_tdata[79:64])
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result loaded over an untaken result");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while another is in work");

	a_fetch_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fetch && st.fetch_done) |=> cmd.extract)
		else $error("fetch end not followed by extraction");

	a_read_path: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !st.read_go) |=> !cmd.fetch)
		else $error("fetch started for an item that reads nothing");

endmodule

// ----- hw/rtl/bsfr_ctrl.sv -----
// Sequencer for the bit stream field reader: handshakes and step commands.
module bsfr_ctrl import bsfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t st,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   m_valid_q, m_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		m_valid_d = m_valid_q && !m_tready;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = st.read_go ? ST_FETCH : ST_DONE;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				if (st.fetch_done)
					state_d = ST_EXTRACT;
			end
			ST_EXTRACT: begin
				cmd.extract = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				// hold the result until the output register is free
				if (!m_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					m_valid_d    = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = m_valid_q;

endmodule

// ----- hw/rtl/bsfr_dp.sv -----
// Datapath for the bit stream field reader: byte store, position, bit window.
module bsfr_dp import bsfr_pkg::*; #(
	parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
	parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  st,
	input  logic [REQ_BITS-1:0]   in_req,
	input  logic [BYTE_BITS-1:0]  in_byte,
	input  logic [CNT_BITS-1:0]   in_cnt,
	output logic [FIELD_BITS-1:0] out_value,
	output logic                  out_ok,
	output logic [POS_BITS-1:0]   out_pos
);

	localparam int LW = $clog2(BUFFER_BYTES + 1);
	localparam int IW = $clog2(BUFFER_BYTES);
	localparam int PW = LW + 3;

	logic [BYTE_BITS-1:0] mem_q [BUFFER_BYTES];
	logic [BYTE_BITS-1:0] rd_q;

	req_e_t                req_q;
	logic [BYTE_BITS-1:0]  bval_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [LW-1:0]         loaded_q;
	logic [LW-1:0]         bidx_q;
	logic [2:0]            boff_q;
	logic [3:0]            k_q;
	logic [3:0]            nbytes_q;
	logic [WIN_BITS-1:0]   win_q;
	logic [FIELD_BITS-1:0] value_q;
	logic                  ok_q;

	logic [PW-1:0]         pos, total, remain, cnt_ext, pos_fwd, pos_back;
	logic                  cnt_ok, fits, back_ok, full, ok_d;
	logic [7:0]            span;
	logic [3:0]            nbytes;
	logic [LW-1:0]         rd_sum;
	logic                  mem_we, mem_re;
	logic [6:0]            nb8, amt;
	logic [WIN_BITS-1:0]   shifted;
	logic [FIELD_BITS:0]   mask;
	logic [PW+POS_BITS-1:0] pos_wide;

	assign pos      = {bidx_q, boff_q};
	assign total    = {loaded_q, 3'b000};
	assign remain   = (total >= pos) ? total - pos : '0;
	assign cnt_ext  = {{(PW-CNT_BITS){1'b0}}, cnt_q};
	assign pos_fwd  = pos + cnt_ext;
	assign pos_back = pos - cnt_ext;
	assign cnt_ok   = cnt_q <= CNT_BITS'(MAX_FIELD_BITS);
	assign fits     = cnt_ok && (cnt_ext <= remain);
	assign back_ok  = cnt_ok && (cnt_ext <= pos);
	assign full     = loaded_q == LW'(BUFFER_BYTES);

	// bytes touched by the field: ceil((offset + count) / 8)
	assign span   = {5'b0, boff_q} + {1'b0, cnt_q} + 8'd7;
	assign nbytes = span[6:3];

	always_comb begin
		unique case (req_q)
			REQ_LOAD:   ok_d = !full;
			REQ_RD_MSB,
			REQ_RD_LSB,
			REQ_SKIP,
			REQ_CHECK:  ok_d = fits;
			REQ_BACK:   ok_d = back_ok;
			REQ_CLEAR:  ok_d = 1'b1;
			default:    ok_d = 1'b0;
		endcase
	end

	assign st.read_go    = (req_q == REQ_RD_MSB || req_q == REQ_RD_LSB) && fits;
	assign st.fetch_done = k_q == nbytes_q;

	assign mem_we = cmd.exec && (req_q == REQ_LOAD) && !full;
	assign mem_re = cmd.fetch && (k_q < nbytes_q);
	assign rd_sum = bidx_q + {{(LW-4){1'b0}}, k_q};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[loaded_q[IW-1:0]] <= bval_q;
		if (mem_re)
			rd_q <= mem_q[rd_sum[IW-1:0]];
	end

	// Field sits in the window as big-endian bytes (MSB-first) or little-endian.
	assign nb8 = {nbytes_q, 3'b000};
	always_comb begin
		if (req_q == REQ_RD_MSB)
			amt = nb8 - {4'b0, boff_q} - cnt_q;
		else
			amt = 7'(WIN_BITS) - nb8 + {4'b0, boff_q};
	end
	assign shifted = win_q >> amt;
	assign mask    = ~({(FIELD_BITS+1){1'b1}} << cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			bidx_q   <= '0;
			boff_q   <= '0;
			k_q      <= '0;
		end else begin
			if (cmd.exec) begin
				k_q <= '0;
				unique case (req_q)
					REQ_LOAD:  if (!full) loaded_q <= loaded_q + 1'b1;
					REQ_SKIP:  if (fits) {bidx_q, boff_q} <= pos_fwd;
					REQ_BACK:  if (back_ok) {bidx_q, boff_q} <= pos_back;
					REQ_CLEAR: begin
						loaded_q <= '0;
						bidx_q   <= '0;
						boff_q   <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.fetch)
				k_q <= k_q + 1'b1;
			// advance past the field once it has been extracted
			if (cmd.extract)
				{bidx_q, boff_q} <= pos_fwd;
		end
	end

	assign pos_wide = {{POS_BITS{1'b0}}, pos};

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q  <= req_e_t'(in_req);
			bval_q <= in_byte;
			cnt_q  <= in_cnt;
		end
		if (cmd.exec) begin
			value_q  <= '0;
			ok_q     <= ok_d;
			nbytes_q <= nbytes;
			win_q    <= '0;
		end
		// the byte read in the previous cycle shifts in
		if (cmd.fetch && k_q != 4'd0) begin
			if (req_q == REQ_RD_MSB)
				win_q <= {win_q[WIN_BITS-BYTE_BITS-1:0], rd_q};
			else
				win_q <= {rd_q, win_q[WIN_BITS-1:BYTE_BITS]};
		end
		if (cmd.extract)
			value_q <= shifted[FIELD_BITS-1:0] & mask[FIELD_BITS-1:0];
		if (cmd.out_load) begin
			out_value <= value_q;
			out_ok    <= ok_q;
			out_pos   <= pos_wide[POS_BITS-1:0];
		end
	end

endmodule

// ----- verif/bit_stream_field_reader_checker.sv -----
// Predicts the bit stream field reader results and checks them against its outputs.
`timescale 1ns / 100ps

module bit_stream_field_reader_checker import bsfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // byte_value[7:0], bit_count[14:8], zero[15]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // field_value[63:0], bit_position[79:64]
	input  logic [0:0]  m_tuser,  // ok[0]
	output int          fail_count,
	output int          pending
);

	localparam int STORE_BYTES = BUFFER_BYTES_DEF;
	localparam int REPORT_MAX  = 40;

	typedef struct packed {
		logic [FIELD_BITS-1:0] value;
		logic                  ok;
		logic [POS_BITS-1:0]   pos;
	} field_result_t;

	field_result_t        expected_fields[$];
	logic [BYTE_BITS-1:0] shadow_store [STORE_BYTES];
	int unsigned          stored_bytes;
	int unsigned          read_pos;

	// Apply one request to the shadow buffer and return the result it should give.
	function automatic field_result_t predict_field(input logic [REQ_BITS-1:0] req,
			input logic [BYTE_BITS-1:0] bval, input int unsigned cnt);
		field_result_t res;
		int unsigned   remain;
		int unsigned   p;
		int unsigned   i;
		logic          cnt_ok;
		res    = '0;
		remain = (stored_bytes * BYTE_BITS >= read_pos) ?
			stored_bytes * BYTE_BITS - read_pos : 0;
		cnt_ok = cnt <= MAX_FIELD_BITS_DEF;
		case (req)
			REQ_LOAD: begin
				if (stored_bytes < STORE_BYTES) begin
					shadow_store[stored_bytes] = bval;
					stored_bytes++;
					res.ok = 1'b1;
				end
			end
			REQ_RD_MSB, REQ_RD_LSB: begin
				if (cnt_ok && cnt <= remain) begin
					for (i = 0; i < cnt; i++) begin
						p = read_pos + i;
						// MSB-first takes bit 7 of each byte first and shifts it up
						if (req == REQ_RD_MSB)
							res.value = {res.value[FIELD_BITS-2:0],
								shadow_store[p >> 3][7 - (p & 7)]};
						else
							res.value[i] = shadow_store[p >> 3][p & 7];
					end
					read_pos += cnt;
					res.ok = 1'b1;
				end
			end
			REQ_SKIP: begin
				if (cnt_ok && cnt <= remain) begin
					read_pos += cnt;
					res.ok = 1'b1;
				end
			end
			REQ_BACK: begin
				if (cnt_ok && cnt <= read_pos) begin
					read_pos -= cnt;
					res.ok = 1'b1;
				end
			end
			REQ_CHECK: begin
				res.ok = cnt_ok && cnt <= remain;
			end
			REQ_CLEAR: begin
				stored_bytes = 0;
				read_pos     = 0;
				res.ok       = 1'b1;
			end
			default: begin
			end
		endcase
		res.pos = read_pos[POS_BITS-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		field_result_t seen;
		field_result_t want;
		if (!arst_n) begin
			stored_bytes = 0;
			read_pos     = 0;
			fail_count   = 0;
			expected_fields.delete();
		end else begin
			// Check the output before queuing this edge's input item.
			if (m_tvalid && m_tready) begin
				seen.value = m_tdata[FIELD_BITS-1:0];
				seen.pos   = m_tdata[FIELD_BITS+POS_BITS-1:FIELD_BITS];
				seen.ok    = m_tuser[0];
				if (expected_fields.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("%0t: unexpected result value %h ok %b pos %0d",
							$time, seen.value, seen.ok, seen.pos);
				end else begin
					want = expected_fields.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display({"%0t: expected value %h ok %b pos %0d, ",
								"actual value %h ok %b pos %0d"},
								$time, want.value, want.ok, want.pos,
								seen.value, seen.ok, seen.pos);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_fields.push_back(predict_field(s_tuser, s_tdata[7:0],
					32'(s_tdata[14:8])));
		end
		pending = expected_fields.size();
	end

endmodule

// ----- verif/bit_stream_field_reader_tb.sv -----
// Stimulus and verdict for the bit stream field reader.
`timescale 1ns / 100ps

module bit_stream_field_reader_tb;
	import bsfr_pkg::*;

	localparam logic [REQ_BITS-1:0] REQ_UNKNOWN = 3'd7;
	localparam int PHASE_ITEMS = 470;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [0:0]  m_tuser;

	int fail_count;
	int pending;
	int items_sent;
	int tx_idle_pct;
	int rx_stall_pct;
	bit hold_request;

	bit_stream_field_reader DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	bit_stream_field_reader_checker field_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offer one item, idling first at random; return at the falling edge after accept.
	task automatic send_item(input logic [REQ_BITS-1:0] req, input logic [7:0] bval,
			input logic [CNT_BITS-1:0] cnt);
		if ($urandom_range(1, 100) <= tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(1, 100) <= tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {1'b0, cnt, bval};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// Mostly counts that fit a field, some small, a few too large.
	function automatic logic [CNT_BITS-1:0] rand_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 7'($urandom_range(0, 16));
		else if (r < 85)
			return 7'($urandom_range(0, 64));
		else if (r < 95)
			return 7'($urandom_range(65, 127));
		return $urandom_range(0, 1) ? 7'd64 : 7'd0;
	endfunction

	// One run: load a few bytes, then walk over them; now and then clear or send junk.
	task automatic send_random_run();
		int r;
		int n;
		logic [REQ_BITS-1:0] req;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			send_item(REQ_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
		end else if (r < 6) begin
			send_item(REQ_UNKNOWN, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
		end else begin
			n = $urandom_range(1, 12);
			repeat (n)
				send_item(REQ_LOAD, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
			n = $urandom_range(1, 6);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					req = REQ_RD_MSB;
				else if (r < 70)
					req = REQ_RD_LSB;
				else if (r < 80)
					req = REQ_SKIP;
				else if (r < 90)
					req = REQ_BACK;
				else
					req = REQ_CHECK;
				send_item(req, 8'($urandom_range(0, 255)), rand_count());
			end
		end
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int n);
		int target;
		target       = items_sent + n;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		while (items_sent < target)
			send_random_run();
	endtask

	// Receiver: random stalls, or one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				m_tready <= ($urandom_range(1, 100) > rx_stall_pct);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("bit_stream_field_reader: mismatch");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		items_sent   = 0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_request = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty buffer: zero counts pass, others run off either end; then nine loads.
		send_item(REQ_RD_MSB, 8'h00, 7'd0);
		send_item(REQ_RD_LSB, 8'hFF, 7'd1);
		send_item(REQ_BACK, 8'h00, 7'd1);
		send_item(REQ_BACK, 8'hFF, 7'd0);
		send_item(REQ_CHECK, 8'h00, 7'd0);
		send_item(REQ_LOAD, 8'h00, 7'd0);
		send_item(REQ_LOAD, 8'hFF, 7'd127);
		send_item(REQ_LOAD, 8'hA5, 7'd64);
		send_item(REQ_LOAD, 8'h3C, 7'd0);
		send_item(REQ_LOAD, 8'h81, 7'd127);
		send_item(REQ_LOAD, 8'h7E, 7'd0);
		send_item(REQ_LOAD, 8'h5A, 7'd64);
		send_item(REQ_LOAD, 8'hC3, 7'd0);
		send_item(REQ_LOAD, 8'h96, 7'd127);
		// Full-width fields at an odd offset span nine bytes.
		send_item(REQ_SKIP, 8'h00, 7'd3);
		send_item(REQ_RD_MSB, 8'hFF, 7'd64);
		send_item(REQ_BACK, 8'h00, 7'd64);
		send_item(REQ_RD_LSB, 8'hFF, 7'd64);
		send_item(REQ_CHECK, 8'h00, 7'd5);
		send_item(REQ_CHECK, 8'hFF, 7'd6);
		send_item(REQ_RD_MSB, 8'h00, 7'd65);
		send_item(REQ_SKIP, 8'hFF, 7'd127);
		send_item(REQ_BACK, 8'h00, 7'd67);
		send_item(REQ_UNKNOWN, 8'hFF, 7'd127);
		send_item(REQ_CLEAR, 8'h00, 7'd0);

		// Hold the receiver off while items keep coming, so the input stalls.
		hold_request = 1'b1;
		run_phase(0, 0, 60);
		run_phase(0, 0, PHASE_ITEMS);
		run_phase(75, 0, PHASE_ITEMS);
		run_phase(0, 75, PHASE_ITEMS);
		run_phase(29, 29, PHASE_ITEMS);

		s_tvalid     <= 1'b0;
		rx_stall_pct = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("bit_stream_field_reader: match");
		else
			$display("bit_stream_field_reader: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/bsfr_pkg.sv
hw/rtl/bsfr_ctrl.sv
hw/rtl/bsfr_dp.sv
hw/rtl/bit_stream_field_reader.sv
verif/bit_stream_field_reader_checker.sv
verif/bit_stream_field_reader_tb.sv
